FILE: hw/rtl/cmbf_pkg.sv
// shared constants and defaults for the feedback comb filter
`timescale 1ns / 1ps

package cmbf_pkg;

   // default sizes for the top-level parameters
   localparam int MAX_DELAY_DEF    = 4096;
   localparam int SAMPLE_WIDTH_DEF = 24;
   localparam int COEF_WIDTH_DEF   = 18;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int LEN_W       = 13;

   localparam logic [CSR_INDEX_W-1:0] REG_DELAY_LENGTH     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FEEDFORWARD_GAIN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FEEDBACK_GAIN    = 2'd2;

   localparam logic [LEN_W-1:0] DELAY_LENGTH_RST = 13'd1;

   // output queue depth, also the limit on beats in flight
   localparam int OUT_DEPTH = 4;

endpackage

FILE: hw/rtl/feedback_comb_filter.sv
// feedback comb filter: v = b0*x + am*d with a circular delay store in ram
// result path: a sample beat passes stage 1 and stage 2 of the pipe, then the output queue
// throughput: one sample per cycle unless OUT_DEPTH results are pending; one ram read and
// write per sample, with the two most recent writes forwarded around the registered read
// reset: synchronous; registers go to their defaults, the delay store reads as zero
// until written (tracked by a high-water mark), so no clearing pass is needed
`timescale 1ns / 1ps

module feedback_comb_filter import cmbf_pkg::*; #(
   parameter int MAX_DELAY    = MAX_DELAY_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
   localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // sample input
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [DATA_W-1:0]      req_tdata,   // [SAMPLE_WIDTH-1:0] sample_in
   // result output
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [DATA_W-1:0]      rsp_tdata,   // [SAMPLE_WIDTH-1:0] sample_out
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int SW     = SAMPLE_WIDTH;
   localparam int CW     = COEF_WIDTH;
   localparam int AW     = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
   localparam int CNT_W  = $clog2(MAX_DELAY + 1);
   localparam int CMP_W  = (LEN_W > CNT_W) ? LEN_W : CNT_W;
   localparam int PEND_W = $clog2(OUT_DEPTH + 1);

   localparam logic signed [CW-1:0] FF_GAIN_RST = CW'(1) << (CW - 2);
   localparam logic [CMP_W-1:0]     MAX_LEN     = CMP_W'(MAX_DELAY);

   logic signed [CW-1:0] ff_gain_ff;
   logic signed [CW-1:0] fb_gain_ff;
   logic [CNT_W-1:0]     eff_len_ff, eff_len_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]     hwm_ff, hwm_in;
   logic [PEND_W-1:0]    pend_ff, pend_in;

   logic [CMP_W-1:0]     len_ext;
   logic [CNT_W-1:0]     idx_inc;
   logic [CNT_W-1:0]     wr_inc;
   logic                 accept;
   logic                 deliver;
   logic                 csr_write;
   logic                 miss;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [SW-1:0]        wr_data;
   logic [SW-1:0]        rd_data;
   logic [SW-1:0]        out_sample;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_tready = (32'(pend_ff) < OUT_DEPTH);
   assign accept     = req_tvalid && req_tready;
   assign deliver    = rsp_tvalid && rsp_tready;

   // an entry at or past the high-water mark has never been written
   assign miss = (CNT_W'(idx_ff) >= hwm_ff);

   always_comb begin
      // a length of zero acts as one, a length past the store acts as the store size
      len_ext = CMP_W'(csr_data[LEN_W-1:0]);
      if (len_ext == '0) begin
         eff_len_in = CNT_W'(1);
      end else if (len_ext > MAX_LEN) begin
         eff_len_in = CNT_W'(MAX_DELAY);
      end else begin
         eff_len_in = len_ext[CNT_W-1:0];
      end

      idx_inc = CNT_W'(idx_ff) + 1'b1;
      idx_in  = idx_ff;
      if (accept) begin
         idx_in = (idx_inc >= eff_len_ff) ? '0 : idx_inc[AW-1:0];
      end

      wr_inc = CNT_W'(wr_addr) + 1'b1;
      hwm_in = hwm_ff;
      if (wr_en && (wr_inc > hwm_ff)) begin
         hwm_in = wr_inc;
      end

      pend_in = pend_ff;
      if (accept && !deliver) begin
         pend_in = pend_ff + 1'b1;
      end else if (deliver && !accept) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ff_gain_ff <= FF_GAIN_RST;
         fb_gain_ff <= '0;
         eff_len_ff <= CNT_W'(DELAY_LENGTH_RST);
         idx_ff     <= '0;
         hwm_ff     <= '0;
         pend_ff    <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_DELAY_LENGTH: begin
                  eff_len_ff <= eff_len_in;
               end
               REG_FEEDFORWARD_GAIN: begin
                  ff_gain_ff <= $signed(csr_data[CW-1:0]);
               end
               REG_FEEDBACK_GAIN: begin
                  fb_gain_ff <= $signed(csr_data[CW-1:0]);
               end
               default: begin
               end
            endcase
         end
         idx_ff  <= idx_in;
         hwm_ff  <= hwm_in;
         pend_ff <= pend_in;
      end
   end

   cmbf_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_DELAY)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   cmbf_pipe #(
      .MAX_DELAY    (MAX_DELAY),
      .SAMPLE_WIDTH (SW),
      .COEF_WIDTH   (CW)
   ) u_pipe (
      .clock            (clock),
      .reset            (reset),
      .issue_valid      (accept),
      .issue_idx        (idx_ff),
      .issue_miss       (miss),
      .issue_sample     ($signed(req_tdata[SW-1:0])),
      .rd_data          (rd_data),
      .feedforward_gain (ff_gain_ff),
      .feedback_gain    (fb_gain_ff),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data)
   );

   cmbf_out_fifo #(
      .WIDTH (SW)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (wr_en),
      .push_data (wr_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_sample)
   );

   assign rsp_tdata = DATA_W'(out_sample);

endmodule

FILE: hw/rtl/cmbf_ram.sv
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module cmbf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents when the same entry is written in that cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/cmbf_pipe.sv
// two-stage multiply, round and saturate datapath with delay-store forwarding
`timescale 1ns / 1ps

module cmbf_pipe import cmbf_pkg::*; #(
   parameter int MAX_DELAY    = MAX_DELAY_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
   localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   // issue side, same cycle as the ram read
   input  logic                           issue_valid,
   input  logic [AW-1:0]                  issue_idx,
   input  logic                           issue_miss,
   input  logic signed [SAMPLE_WIDTH-1:0] issue_sample,
   input  logic [SAMPLE_WIDTH-1:0]        rd_data,
   input  logic signed [COEF_WIDTH-1:0]   feedforward_gain,
   input  logic signed [COEF_WIDTH-1:0]   feedback_gain,
   // write-back and result
   output logic                           wr_en,
   output logic [AW-1:0]                  wr_addr,
   output logic [SAMPLE_WIDTH-1:0]        wr_data
);

   localparam int SW    = SAMPLE_WIDTH;
   localparam int CW    = COEF_WIDTH;
   localparam int PW    = SW + CW;
   localparam int SUM_W = PW + 1;
   localparam int FRAC  = CW - 2;
   localparam int RW    = SUM_W - FRAC;

   localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC - 1);
   localparam logic [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

   // stage 1: ram data back, input product
   logic                 s1_valid_ff;
   logic [AW-1:0]        s1_idx_ff;
   logic                 s1_miss_ff;
   logic signed [SW-1:0] s1_x_ff;

   // stage 2: feedback product, sum, round, saturate
   logic                 s2_valid_ff;
   logic [AW-1:0]        s2_idx_ff;
   logic signed [PW-1:0] s2_p1_ff;
   logic signed [SW-1:0] s2_d_ff;

   // value written to the ram on the previous edge, not yet seen by a read
   logic                 wb_valid_ff;
   logic [AW-1:0]        wb_idx_ff;
   logic [SW-1:0]        wb_v_ff;

   logic signed [PW-1:0]    p1_in;
   logic signed [SW-1:0]    d_in;
   logic signed [PW-1:0]    p2;
   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] sum_shift;
   logic signed [RW-1:0]    rnd;
   logic [SW-1:0]           v;

   always_comb begin
      p1_in = s1_x_ff * feedforward_gain;
      // youngest write to the same entry wins
      if (s2_valid_ff && (s2_idx_ff == s1_idx_ff)) begin
         d_in = $signed(v);
      end else if (wb_valid_ff && (wb_idx_ff == s1_idx_ff)) begin
         d_in = $signed(wb_v_ff);
      end else if (s1_miss_ff) begin
         d_in = '0;
      end else begin
         d_in = $signed(rd_data);
      end
   end

   always_comb begin
      p2        = s2_d_ff * feedback_gain;
      sum       = SUM_W'(s2_p1_ff) + SUM_W'(p2) + HALF;
      sum_shift = sum >>> FRAC;
      rnd       = sum_shift[RW-1:0];
      if ((&rnd[RW-1:SW-1]) || !(|rnd[RW-1:SW-1])) begin
         v = rnd[SW-1:0];
      end else if (rnd[RW-1]) begin
         v = SMIN;
      end else begin
         v = SMAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         wb_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue_valid;
         s2_valid_ff <= s1_valid_ff;
         wb_valid_ff <= s2_valid_ff;
      end
      s1_idx_ff  <= issue_idx;
      s1_miss_ff <= issue_miss;
      s1_x_ff    <= issue_sample;
      s2_idx_ff  <= s1_idx_ff;
      s2_p1_ff   <= p1_in;
      s2_d_ff    <= d_in;
      wb_idx_ff  <= s2_idx_ff;
      wb_v_ff    <= v;
   end

   assign wr_en   = s2_valid_ff;
   assign wr_addr = s2_idx_ff;
   assign wr_data = v;

endmodule

FILE: hw/rtl/cmbf_out_fifo.sv
// small output queue that decouples the result side from the pipeline
`timescale 1ns / 1ps

module cmbf_out_fifo import cmbf_pkg::*; #(
   parameter int WIDTH = 24,
   localparam int PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1,
   localparam int CNT_W = $clog2(OUT_DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] entry_ff [OUT_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == OUT_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == OUT_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: tb/sv/feedback_comb_filter_tb.sv
// testbench for the feedback comb filter: directed and random stream traffic checked beat by beat
`timescale 1ns / 1ps

module feedback_comb_filter_tb;
   import cmbf_pkg::*;

   localparam int SAMPLE_W = SAMPLE_WIDTH_DEF;
   localparam int COEF_W = COEF_WIDTH_DEF;
   localparam int FRAC_BITS = COEF_W - 2;
   localparam longint SAT_HI = 2 ** (SAMPLE_W - 1) - 1;
   localparam longint SAT_LO = -(2 ** (SAMPLE_W - 1));
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 850;
   localparam int LONG_HOLD = 300;
   localparam int IDLE_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [SAMPLE_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   feedback_comb_filter u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // samples waiting to be sent, head is the beat on the bus
   logic [SAMPLE_W-1:0] sample_queue[$];
   logic [SAMPLE_W-1:0] expected_samples[$];

   // predicted filter state
   logic signed [SAMPLE_W-1:0] echo_line[MAX_DELAY_DEF];
   int unsigned echo_ptr;
   logic [LEN_W-1:0] span_reg;
   logic signed [COEF_W-1:0] ff_gain;
   logic signed [COEF_W-1:0] fb_gain;

   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   logic csr_taken = 1'b0;
   int idle_cycles = 0;
   int error_count = 0;
   int rsp_count = 0;

   int sender_bursty = 0;
   int burst_left = 0;
   int gap_left = 0;
   int rx_mode = 0;
   int rx_phase = 0;
   int hold_left = 0;
   logic long_hold_req = 1'b0;

   task automatic report_error(string msg);
      $display("error at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] comb_response(logic signed [SAMPLE_W-1:0] x);
      longint prod_x;
      longint prod_d;
      longint acc;
      logic signed [SAMPLE_W-1:0] d;
      int unsigned span;
      d = echo_line[echo_ptr];
      prod_x = longint'(x) * longint'(ff_gain);
      prod_d = longint'(d) * longint'(fb_gain);
      // round half up at the sample scale
      acc = (prod_x + prod_d + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (acc > SAT_HI) acc = SAT_HI;
      else if (acc < SAT_LO) acc = SAT_LO;
      echo_line[echo_ptr] = acc[SAMPLE_W-1:0];
      if (span_reg == 0) span = 1;
      else if (span_reg > MAX_DELAY_DEF) span = MAX_DELAY_DEF;
      else span = 32'(span_reg);
      // an index left past a shrunk length still wraps to zero here
      echo_ptr = (echo_ptr + 1 >= span) ? 0 : echo_ptr + 1;
      return acc[SAMPLE_W-1:0];
   endfunction

   // posedge sampling: predictor, result checker and watchdog
   always @(posedge clock) begin : beat_monitor
      logic [SAMPLE_W-1:0] want;
      if (reset) begin
         for (int i = 0; i < MAX_DELAY_DEF; i++) echo_line[i] = '0;
         echo_ptr = 0;
         span_reg = DELAY_LENGTH_RST;
         ff_gain = 18'sd65536;
         fb_gain = '0;
         req_taken = 1'b0;
         rsp_taken = 1'b0;
         csr_taken = 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken = req_tvalid && req_tready;
         rsp_taken = rsp_tvalid && rsp_tready;
         csr_taken = csr_valid && csr_ready;
         if (csr_taken) begin
            case (csr_index)
               REG_DELAY_LENGTH: span_reg = csr_data[LEN_W-1:0];
               REG_FEEDFORWARD_GAIN: ff_gain = csr_data[COEF_W-1:0];
               REG_FEEDBACK_GAIN: fb_gain = csr_data[COEF_W-1:0];
               default: ;
            endcase
         end
         if (req_taken) expected_samples.push_back(comb_response(req_tdata));
         if (rsp_taken) begin
            if (expected_samples.size() == 0) begin
               report_error($sformatf("result beat %0d with nothing expected: %h",
                                      rsp_count, rsp_tdata));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_tdata !== want)
                  report_error($sformatf("result beat %0d sample_out %h, expected %h",
                                         rsp_count, rsp_tdata, want));
            end
            rsp_count++;
         end
         if (req_taken || rsp_taken || csr_taken) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("timeout: %0d samples queued, %0d results outstanding",
                        sample_queue.size(), expected_samples.size());
               $display("Regression FAIL");
               $finish;
            end
         end
      end
   end

   // sample sender, continuous or in bursts with random gaps
   always @(negedge clock) begin : sample_driver
      logic offer;
      offer = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_taken) sample_queue.delete(0);
         if (req_tvalid && !req_taken) begin
            offer = 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (sample_queue.size() > 0) begin
            offer = 1'b1;
            if (sender_bursty != 0) begin
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(16, 1);
                  gap_left = ($urandom_range(9) == 0) ? $urandom_range(30, 10)
                                                      : $urandom_range(4, 1);
               end
            end
         end
      end
      req_tvalid <= offer;
      if (offer) req_tdata <= sample_queue[0];
   end

   // result receiver with its own stall pattern
   always @(negedge clock) begin : result_sink
      logic ready;
      ready = 1'b1;
      rx_phase = (rx_phase + 1) % 9;
      if (reset) begin
         ready = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         ready = 1'b0;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = LONG_HOLD - 1;
         ready = 1'b0;
      end else begin
         case (rx_mode)
            1: ready = ($urandom_range(1) != 0);
            2: ready = $urandom_range(3) != 0;
            3: ready = rx_phase < 5;
            default: ready = 1'b1;
         endcase
      end
      rsp_tready <= ready;
   end

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(7))
         0: return SAT_HI[SAMPLE_W-1:0];
         1: return SAT_LO[SAMPLE_W-1:0];
         2: return SAMPLE_W'($urandom_range(511)) - SAMPLE_W'(256);
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   // random upper bits that the register must drop
   function automatic logic [CSR_DATA_W-1:0] pick_gain(logic stable);
      logic [CSR_DATA_W-1:0] v;
      v = $urandom();
      case ($urandom_range(5))
         0: v[COEF_W-1:0] = 18'h20000;
         1: v[COEF_W-1:0] = 18'h1ffff;
         2: ;
         default: begin
            // keep the loop gain below one most of the time
            if (stable) v[COEF_W-1:0] = COEF_W'($urandom_range(131072)) - COEF_W'(65536);
         end
      endcase
      return v;
   endfunction

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(negedge clock); while (!csr_taken);
   endtask

   // wait for the sender to empty and every result to come back
   task automatic drain();
      do @(negedge clock);
      while (sample_queue.size() != 0 || req_tvalid || expected_samples.size() != 0);
   endtask

   initial begin
      int sent;
      int n;
      logic [CSR_DATA_W-1:0] len_word;
      logic first;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults pass samples through
      sample_queue.push_back(SAT_HI[SAMPLE_W-1:0]);
      sample_queue.push_back(SAT_LO[SAMPLE_W-1:0]);
      sample_queue.push_back('0);
      sample_queue.push_back(24'h000001);
      sample_queue.push_back(24'hffffff);
      drain();

      // gains at both extremes, saturating both ways
      write_reg(REG_FEEDFORWARD_GAIN, 32'h0002_0000);
      write_reg(REG_FEEDBACK_GAIN, 32'h0001_ffff);
      write_reg(REG_DELAY_LENGTH, 32'd1);
      csr_valid <= 1'b0;
      sample_queue.push_back(SAT_HI[SAMPLE_W-1:0]);
      sample_queue.push_back(SAT_LO[SAMPLE_W-1:0]);
      sample_queue.push_back('0);
      sample_queue.push_back(24'h000001);
      drain();

      // zero length acts as one, unused index is ignored
      write_reg(REG_DELAY_LENGTH, 32'd0);
      write_reg(REG_UNUSED, 32'hffff_ffff);
      csr_valid <= 1'b0;
      sample_queue.push_back(pick_sample());
      sample_queue.push_back(pick_sample());
      drain();

      // oversized length clamps, upper register bits dropped
      write_reg(REG_DELAY_LENGTH, 32'hffff_ffff);
      write_reg(REG_FEEDFORWARD_GAIN, 32'hfffc_8000);
      write_reg(REG_FEEDBACK_GAIN, 32'h5554_c000);
      csr_valid <= 1'b0;
      sample_queue.push_back(24'h400000);
      sample_queue.push_back(24'hc00000);
      sample_queue.push_back(24'h123456);
      drain();

      // shrink length below the current index
      write_reg(REG_DELAY_LENGTH, 32'd2);
      csr_valid <= 1'b0;
      sample_queue.push_back(24'h654321);
      sample_queue.push_back(24'h0000ff);
      drain();

      sent = 0;
      first = 1'b1;
      while (sent < RANDOM_ITEMS) begin
         n = $urandom_range(100, 40);
         if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
         if (first || $urandom_range(3) != 0) begin
            len_word = $urandom();
            case ($urandom_range(9))
               0: len_word[LEN_W-1:0] = '0;
               1: len_word[LEN_W-1:0] = LEN_W'(MAX_DELAY_DEF);
               2: len_word[LEN_W-1:0] = LEN_W'($urandom_range(8191, MAX_DELAY_DEF + 1));
               3: len_word[LEN_W-1:0] = LEN_W'($urandom_range(MAX_DELAY_DEF - 1, 64));
               default: len_word[LEN_W-1:0] = LEN_W'($urandom_range(32, 1));
            endcase
            write_reg(REG_DELAY_LENGTH, len_word);
         end
         if (first || $urandom_range(2) != 0) write_reg(REG_FEEDFORWARD_GAIN, pick_gain(1'b0));
         if (first || $urandom_range(2) != 0) write_reg(REG_FEEDBACK_GAIN, pick_gain(1'b1));
         csr_valid <= 1'b0;
         if (first) begin
            // back the block up against a stalled receiver
            sender_bursty = 0;
            rx_mode = 0;
            long_hold_req = 1'b1;
         end else begin
            sender_bursty = $urandom_range(1);
            rx_mode = $urandom_range(3);
         end
         burst_left = 0;
         repeat (n) sample_queue.push_back(pick_sample());
         sent += n;
         drain();
         first = 1'b0;
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
